/* hw/rtl/rbli_pkg.sv */
// Shared constants, control codes and types for the rigid body integrator.
package rbli_pkg;

    localparam int DEF_FRAC_BITS = 16;
    localparam int DEF_WORD_BITS = 32;

    // Command field codes
    localparam logic CMD_INTEGRATE = 1'b0;
    localparam logic CMD_IMPULSE   = 1'b1;

    // Configuration register indexes
    localparam int CFG_ADDR_BITS = 2;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_BODY_MASS = 2'd0;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_GRAVITY_X = 2'd1;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_GRAVITY_Y = 2'd2;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_GRAVITY_Z = 2'd3;

    // Accumulator operations of the shared multiply-accumulate unit
    localparam logic [1:0] ACC_HOLD = 2'd0;
    localparam logic [1:0] ACC_LOAD = 2'd1;
    localparam logic [1:0] ACC_ADD  = 2'd2;
    localparam logic [1:0] ACC_SUB  = 2'd3;

    typedef struct packed {
        logic [1:0] acc_op;   // what to do with the registered product
        logic       fin_wide; // round away one extra fraction bit
    } t_mac_ctl;

    // Numerator width of the divider: time step or one in fixed point
    function automatic int num_bits(input int word_bits, input int frac_bits);
        return (word_bits - 1 > frac_bits + 1) ? word_bits - 1 : frac_bits + 1;
    endfunction

    // Multiplier operand width: lever words and the power-of-two scalings fit
    function automatic int mul_bits(input int word_bits, input int frac_bits);
        return (word_bits + 1 > frac_bits + 3) ? word_bits + 1 : frac_bits + 3;
    endfunction

endpackage

/* hw/rtl/rbli_div.sv */
// Restoring divider, one quotient bit per cycle, rounded and saturated quotient.
module rbli_div #(
    parameter int FRAC_BITS = rbli_pkg::DEF_FRAC_BITS,
    parameter int WORD_BITS = rbli_pkg::DEF_WORD_BITS,
    localparam int NUM_BITS = rbli_pkg::num_bits(WORD_BITS, FRAC_BITS)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [NUM_BITS-1:0]  i_num,
    input  logic [WORD_BITS-2:0] i_den,
    output logic                 o_done,
    output logic [WORD_BITS-1:0] o_quo
);
    import rbli_pkg::*;

    localparam int DVD_BITS = NUM_BITS + FRAC_BITS;
    localparam int CNT_BITS = $clog2(DVD_BITS + 1);
    localparam logic [WORD_BITS:0]   WMAX_X = {2'b00, {(WORD_BITS - 1){1'b1}}};
    localparam logic [WORD_BITS-1:0] QSAT   = {1'b1, {(WORD_BITS - 1){1'b0}}};

    logic                 r_busy, n_busy;
    logic [CNT_BITS-1:0]  r_cnt, n_cnt;
    logic [DVD_BITS-1:0]  r_dvd;
    logic [WORD_BITS-2:0] r_den;
    logic [WORD_BITS-2:0] r_rem;
    logic [WORD_BITS-1:0] r_quo;

    logic [WORD_BITS-1:0] rem_sh;
    logic                 ge;
    logic [WORD_BITS-1:0] rem_diff;
    logic [WORD_BITS:0]   quo_sh;
    logic [WORD_BITS-2:0] den_m_rem;
    logic                 rnd_up;
    logic [WORD_BITS:0]   quo_rnd;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    always_comb begin
        rem_sh   = {r_rem, r_dvd[DVD_BITS-1]};
        ge       = rem_sh >= {1'b0, r_den};
        rem_diff = rem_sh - {1'b0, r_den};
        quo_sh   = {r_quo, ge};
    end

    // Round to nearest on the final remainder, clamp to the largest word
    always_comb begin
        den_m_rem = r_den - r_rem;
        rnd_up    = r_rem >= den_m_rem;
        quo_rnd   = {1'b0, r_quo} + {{WORD_BITS{1'b0}}, rnd_up};
        o_quo     = (quo_rnd > WMAX_X) ? WMAX_X[WORD_BITS-1:0] : quo_rnd[WORD_BITS-1:0];
        o_done    = r_busy && (r_cnt == '0);
    end

    // Sequence control
    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_BITS'(DVD_BITS);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                n_busy = 1'b0;
            end else begin
                n_cnt = r_cnt - CNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
    end

    // Datapath: load on start, advance one bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= {i_num, {FRAC_BITS{1'b0}}};
            r_den <= i_den;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy && (r_cnt != '0)) begin
            r_dvd <= {r_dvd[DVD_BITS-2:0], 1'b0};
            r_rem <= ge ? rem_diff[WORD_BITS-2:0] : rem_sh[WORD_BITS-2:0];
            r_quo <= (quo_sh > WMAX_X) ? QSAT : quo_sh[WORD_BITS-1:0];
        end
    end

    a_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> (i_den != '0))
        else $error("divider started with a zero divisor");

    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_rem < r_den))
        else $error("partial remainder not below divisor");

    a_quo_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_quo <= QSAT))
        else $error("partial quotient above saturation mark");

    a_done_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !i_start) |=> !r_busy)
        else $error("divider stays busy after done");

endmodule

/* hw/rtl/rbli_mac.sv */
// Shared signed multiplier, wide accumulator and round-shift-saturate stage.
module rbli_mac #(
    parameter int FRAC_BITS = rbli_pkg::DEF_FRAC_BITS,
    parameter int WORD_BITS = rbli_pkg::DEF_WORD_BITS,
    localparam int MUL_BITS = rbli_pkg::mul_bits(WORD_BITS, FRAC_BITS)
) (
    input  logic                        i_clk,
    input  logic signed [MUL_BITS-1:0]  i_a,
    input  logic signed [MUL_BITS-1:0]  i_b,
    input  rbli_pkg::t_mac_ctl          i_ctl,
    output logic signed [WORD_BITS-1:0] o_result
);
    import rbli_pkg::*;

    localparam int PRD_BITS = 2 * MUL_BITS;
    localparam int ACC_BITS = PRD_BITS + 2;
    localparam logic [WORD_BITS-1:0] WMAX_W = {1'b0, {(WORD_BITS - 1){1'b1}}};
    localparam logic signed [ACC_BITS-1:0] WMAX_A = ACC_BITS'(WMAX_W);
    localparam logic signed [ACC_BITS-1:0] WMIN_A = ~WMAX_A;
    localparam logic signed [ACC_BITS-1:0] HALF_N = ACC_BITS'(1) << (FRAC_BITS - 1);
    localparam logic signed [ACC_BITS-1:0] HALF_W = ACC_BITS'(1) << FRAC_BITS;

    logic signed [PRD_BITS-1:0] r_prod;
    logic signed [ACC_BITS-1:0] r_acc;
    logic signed [ACC_BITS-1:0] prod_x;
    logic signed [ACC_BITS-1:0] rnd_v;
    logic signed [ACC_BITS-1:0] sh_v;

    // Register the product of this cycle's operands
    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign prod_x = {{2{r_prod[PRD_BITS-1]}}, r_prod};

    // Fold the previous product into the running sum
    always_ff @(posedge i_clk) begin
        case (i_ctl.acc_op)
            ACC_LOAD: r_acc <= prod_x;
            ACC_ADD:  r_acc <= r_acc + prod_x;
            ACC_SUB:  r_acc <= r_acc - prod_x;
            default:  r_acc <= r_acc;
        endcase
    end

    // Round to nearest with ties up, drop the fraction, clamp to a word
    always_comb begin
        rnd_v = r_acc + (i_ctl.fin_wide ? HALF_W : HALF_N);
        sh_v  = i_ctl.fin_wide ? (rnd_v >>> (FRAC_BITS + 1)) : (rnd_v >>> FRAC_BITS);
        if (sh_v > WMAX_A) begin
            o_result = WMAX_A[WORD_BITS-1:0];
        end else if (sh_v < WMIN_A) begin
            o_result = WMIN_A[WORD_BITS-1:0];
        end else begin
            o_result = sh_v[WORD_BITS-1:0];
        end
    end

endmodule

/* hw/rtl/rigid_body_linear_integrator_unit.sv */
// Work per item: the bit-serial divider, then the sums on the shared multiply-accumulate unit,
// velocity and position per axis for an integrate item, velocity per axis and then spin for
// an impulse item. With zero mass the divider is skipped and an integrate item first scales
// the time step by the largest inverse mass.
// One item at a time; the next is taken in the cycle after the result is handed on.
// Synchronous active-low reset: state vectors zero, mass one, gravity zero, no result.
module rigid_body_linear_integrator_unit #(
    parameter int FRAC_BITS = rbli_pkg::DEF_FRAC_BITS,
    parameter int WORD_BITS = rbli_pkg::DEF_WORD_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [rbli_pkg::CFG_ADDR_BITS-1:0] i_cfg_addr,
    input  logic [WORD_BITS-1:0]               i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic                               i_command,
    input  logic signed [WORD_BITS-1:0]        i_vec_x,
    input  logic signed [WORD_BITS-1:0]        i_vec_y,
    input  logic signed [WORD_BITS-1:0]        i_vec_z,
    input  logic signed [WORD_BITS-1:0]        i_point_x,
    input  logic signed [WORD_BITS-1:0]        i_point_y,
    input  logic signed [WORD_BITS-1:0]        i_point_z,
    input  logic [WORD_BITS-2:0]               i_time_step,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [WORD_BITS-1:0]        o_pos_x,
    output logic signed [WORD_BITS-1:0]        o_pos_y,
    output logic signed [WORD_BITS-1:0]        o_pos_z,
    output logic signed [WORD_BITS-1:0]        o_vel_x,
    output logic signed [WORD_BITS-1:0]        o_vel_y,
    output logic signed [WORD_BITS-1:0]        o_vel_z,
    output logic signed [WORD_BITS-1:0]        o_spin_x,
    output logic signed [WORD_BITS-1:0]        o_spin_y,
    output logic signed [WORD_BITS-1:0]        o_spin_z
);
    import rbli_pkg::*;

    localparam int NUM_BITS = num_bits(WORD_BITS, FRAC_BITS);
    localparam int MUL_BITS = mul_bits(WORD_BITS, FRAC_BITS);

    localparam logic [WORD_BITS-1:0] WMAX_W = {1'b0, {(WORD_BITS - 1){1'b1}}};
    localparam logic [WORD_BITS-2:0] ONE_U  = (WORD_BITS - 1)'(1) << FRAC_BITS;
    localparam logic [NUM_BITS-1:0]  ONE_N  = NUM_BITS'(1) << FRAC_BITS;
    localparam logic signed [MUL_BITS-1:0] ONE_M  = MUL_BITS'(1) << FRAC_BITS;
    localparam logic signed [MUL_BITS-1:0] TWO_M  = MUL_BITS'(1) << (FRAC_BITS + 1);
    localparam logic signed [MUL_BITS-1:0] WMAX_M = MUL_BITS'(WMAX_W);

    // Sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_MAC  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    // Sums run on the shared multiply-accumulate unit
    localparam logic [2:0] K_ZSC  = 3'd0; // time step times largest inverse mass
    localparam logic [2:0] K_VELI = 3'd1; // velocity, integrate
    localparam logic [2:0] K_POS  = 3'd2; // position, trapezoidal
    localparam logic [2:0] K_VELP = 3'd3; // velocity, impulse
    localparam logic [2:0] K_SPIN = 3'd4; // angular impulse, cross product

    localparam logic [1:0] AXIS_FIRST = 2'd0;
    localparam logic [1:0] AXIS_LAST  = 2'd2;

    // Configuration
    logic [WORD_BITS-2:0]        r_mass;
    logic signed [WORD_BITS-1:0] r_grav [3];

    // Body state
    logic signed [WORD_BITS-1:0] r_pos  [3];
    logic signed [WORD_BITS-1:0] r_vel  [3];
    logic signed [WORD_BITS-1:0] r_spin [3];
    logic signed [WORD_BITS-1:0] r_vold;

    // Item being worked on
    logic                        r_cmd;
    logic [WORD_BITS-2:0]        r_dt;
    logic signed [WORD_BITS-1:0] r_vec [3];
    logic signed [WORD_BITS:0]   r_lev [3];
    logic [WORD_BITS-1:0]        r_scale;

    // Sequencer
    logic [1:0] r_state, n_state;
    logic [2:0] r_kind, n_kind;
    logic [1:0] r_axis, n_axis;
    logic [2:0] r_term, n_term;

    // Result register
    logic                        r_out_valid;
    logic signed [WORD_BITS-1:0] r_out_pos  [3];
    logic signed [WORD_BITS-1:0] r_out_vel  [3];
    logic signed [WORD_BITS-1:0] r_out_spin [3];

    logic                        in_acc;
    logic                        out_load;
    logic                        div_start;
    logic                        div_done;
    logic [WORD_BITS-1:0]        div_quo;
    logic [NUM_BITS-1:0]         div_num;
    logic [2:0]                  n_terms;
    logic                        fin_step;
    logic                        axis_last;
    logic [1:0]                  ax_j, ax_k;
    logic signed [MUL_BITS-1:0]  mul_a, mul_b;
    logic signed [MUL_BITS-1:0]  dt_m, scale_m;
    t_mac_ctl                    mac_ctl;
    logic signed [WORD_BITS-1:0] mac_res;

    function automatic logic signed [MUL_BITS-1:0] ext_w(input logic signed [WORD_BITS-1:0] v);
        return MUL_BITS'(v);
    endfunction

    function automatic logic signed [MUL_BITS-1:0] ext_l(input logic signed [WORD_BITS:0] v);
        return MUL_BITS'(v);
    endfunction

    assign in_acc     = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign out_load   = (r_state == S_DONE) && (!r_out_valid || i_out_ready);
    assign axis_last  = (r_axis == AXIS_LAST);
    assign fin_step   = (r_state == S_MAC) && (r_term == n_terms + 3'd1);
    assign div_num    = (i_command == CMD_INTEGRATE) ? NUM_BITS'(i_time_step) : ONE_N;

    // Terms in each sum
    always_comb begin
        case (r_kind)
            K_ZSC:   n_terms = 3'd1;
            K_VELP:  n_terms = 3'd2;
            default: n_terms = 3'd3;
        endcase
    end

    // Other two axes for the cross product
    always_comb begin
        case (r_axis)
            2'd0:    begin ax_j = 2'd1; ax_k = 2'd2; end
            2'd1:    begin ax_j = 2'd2; ax_k = 2'd0; end
            default: begin ax_j = 2'd0; ax_k = 2'd1; end
        endcase
    end

    // Pick the multiplier operands of the current term
    always_comb begin
        dt_m    = MUL_BITS'({1'b0, r_dt});
        scale_m = MUL_BITS'(r_scale);
        mul_a   = '0;
        mul_b   = '0;
        case (r_kind)
            K_ZSC: begin
                mul_a = dt_m;
                mul_b = WMAX_M;
            end
            K_VELI: begin
                case (r_term)
                    3'd0:    begin mul_a = ext_w(r_vec[r_axis]);  mul_b = scale_m; end
                    3'd1:    begin mul_a = ext_w(r_grav[r_axis]); mul_b = dt_m;    end
                    default: begin mul_a = ext_w(r_vel[r_axis]);  mul_b = ONE_M;   end
                endcase
            end
            K_POS: begin
                case (r_term)
                    3'd0:    begin mul_a = ext_w(r_vel[r_axis]);  mul_b = dt_m;  end
                    3'd1:    begin mul_a = ext_w(r_vold);         mul_b = dt_m;  end
                    default: begin mul_a = ext_w(r_pos[r_axis]);  mul_b = TWO_M; end
                endcase
            end
            K_VELP: begin
                case (r_term)
                    3'd0:    begin mul_a = ext_w(r_vec[r_axis]);  mul_b = scale_m; end
                    default: begin mul_a = ext_w(r_vel[r_axis]);  mul_b = ONE_M;   end
                endcase
            end
            K_SPIN: begin
                case (r_term)
                    3'd0:    begin mul_a = ext_l(r_lev[ax_j]);    mul_b = ext_w(r_vec[ax_k]); end
                    3'd1:    begin mul_a = ext_l(r_lev[ax_k]);    mul_b = ext_w(r_vec[ax_j]); end
                    default: begin mul_a = ext_w(r_spin[r_axis]); mul_b = ONE_M;              end
                endcase
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Accumulate the product of the previous term; the second cross term subtracts
    always_comb begin
        mac_ctl.fin_wide = (r_kind == K_POS);
        if ((r_state != S_MAC) || (r_term == 3'd0) || (r_term > n_terms)) begin
            mac_ctl.acc_op = ACC_HOLD;
        end else if (r_term == 3'd1) begin
            mac_ctl.acc_op = ACC_LOAD;
        end else if ((r_kind == K_SPIN) && (r_term == 3'd2)) begin
            mac_ctl.acc_op = ACC_SUB;
        end else begin
            mac_ctl.acc_op = ACC_ADD;
        end
    end

    // Sequencer next state
    always_comb begin
        n_state   = r_state;
        n_kind    = r_kind;
        n_axis    = r_axis;
        n_term    = r_term;
        div_start = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_axis = AXIS_FIRST;
                    n_term = '0;
                    if (r_mass != '0) begin
                        div_start = 1'b1;
                        n_state   = S_DIV;
                    end else begin
                        n_state = S_MAC;
                        n_kind  = (i_command == CMD_INTEGRATE) ? K_ZSC : K_VELP;
                    end
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_MAC;
                    n_kind  = (r_cmd == CMD_INTEGRATE) ? K_VELI : K_VELP;
                end
            end
            S_MAC: begin
                if (fin_step) begin
                    n_term = '0;
                    case (r_kind)
                        K_ZSC:  n_kind = K_VELI;
                        K_VELI: n_kind = K_POS;
                        K_POS: begin
                            if (axis_last) begin
                                n_state = S_DONE;
                            end else begin
                                n_kind = K_VELI;
                                n_axis = r_axis + 2'd1;
                            end
                        end
                        K_VELP: begin
                            if (axis_last) begin
                                n_kind = K_SPIN;
                                n_axis = AXIS_FIRST;
                            end else begin
                                n_axis = r_axis + 2'd1;
                            end
                        end
                        K_SPIN: begin
                            if (axis_last) begin
                                n_state = S_DONE;
                            end else begin
                                n_axis = r_axis + 2'd1;
                            end
                        end
                        default: n_state = S_DONE;
                    endcase
                end else begin
                    n_term = r_term + 3'd1;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_kind  <= K_ZSC;
            r_axis  <= AXIS_FIRST;
            r_term  <= '0;
        end else begin
            r_state <= n_state;
            r_kind  <= n_kind;
            r_axis  <= n_axis;
            r_term  <= n_term;
        end
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mass    <= ONE_U;
            r_grav[0] <= '0;
            r_grav[1] <= '0;
            r_grav[2] <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_BODY_MASS: r_mass    <= i_cfg_data[WORD_BITS-2:0];
                CFG_GRAVITY_X: r_grav[0] <= i_cfg_data;
                CFG_GRAVITY_Y: r_grav[1] <= i_cfg_data;
                CFG_GRAVITY_Z: r_grav[2] <= i_cfg_data;
                default:       r_mass    <= r_mass;
            endcase
        end
    end

    // Capture the item; the lever uses the position before this item
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cmd    <= i_command;
            r_dt     <= i_time_step;
            r_vec[0] <= i_vec_x;
            r_vec[1] <= i_vec_y;
            r_vec[2] <= i_vec_z;
            r_lev[0] <= {i_point_x[WORD_BITS-1], i_point_x} - {r_pos[0][WORD_BITS-1], r_pos[0]};
            r_lev[1] <= {i_point_y[WORD_BITS-1], i_point_y} - {r_pos[1][WORD_BITS-1], r_pos[1]};
            r_lev[2] <= {i_point_z[WORD_BITS-1], i_point_z} - {r_pos[2][WORD_BITS-1], r_pos[2]};
        end
    end

    // Scale factor: quotient, largest inverse mass, or its product with the step
    always_ff @(posedge i_clk) begin
        if (in_acc && (r_mass == '0)) begin
            r_scale <= WMAX_W;
        end else if ((r_state == S_DIV) && div_done) begin
            r_scale <= div_quo;
        end else if (fin_step && (r_kind == K_ZSC)) begin
            r_scale <= mac_res;
        end
    end

    // Write back each finished sum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_pos[i]  <= '0;
                r_vel[i]  <= '0;
                r_spin[i] <= '0;
            end
        end else if (fin_step) begin
            case (r_kind)
                K_VELI: r_vel[r_axis]  <= mac_res;
                K_POS:  r_pos[r_axis]  <= mac_res;
                K_VELP: r_vel[r_axis]  <= mac_res;
                K_SPIN: r_spin[r_axis] <= mac_res;
                default: r_vel[r_axis] <= r_vel[r_axis];
            endcase
        end
    end

    // Keep the old velocity for the trapezoidal position sum
    always_ff @(posedge i_clk) begin
        if (fin_step && (r_kind == K_VELI)) begin
            r_vold <= r_vel[r_axis];
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            for (int i = 0; i < 3; i++) begin
                r_out_pos[i]  <= r_pos[i];
                r_out_vel[i]  <= r_vel[i];
                r_out_spin[i] <= r_spin[i];
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_pos_x  = r_out_pos[0];
    assign o_pos_y  = r_out_pos[1];
    assign o_pos_z  = r_out_pos[2];
    assign o_vel_x  = r_out_vel[0];
    assign o_vel_y  = r_out_vel[1];
    assign o_vel_z  = r_out_vel[2];
    assign o_spin_x = r_out_spin[0];
    assign o_spin_y = r_out_spin[1];
    assign o_spin_z = r_out_spin[2];

    rbli_div #(
        .FRAC_BITS (FRAC_BITS),
        .WORD_BITS (WORD_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (r_mass),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    rbli_mac #(
        .FRAC_BITS (FRAC_BITS),
        .WORD_BITS (WORD_BITS)
    ) u_mac (
        .i_clk    (i_clk),
        .i_a      (mul_a),
        .i_b      (mul_b),
        .i_ctl    (mac_ctl),
        .o_result (mac_res)
    );

    a_accept_starts_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> ((r_state == S_DIV) || (r_state == S_MAC)))
        else $error("accepted item did not start work");

    a_term_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MAC) |-> (r_term <= n_terms + 3'd1))
        else $error("term counter ran past end of sum");

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV))
        else $error("divider finished outside its state");

endmodule
